// ----- rtl/lvr_pkg.sv -----
// Package for the light volume radius block: item types, stage map, constants.
// Used by light_volume_radius and its checker; depends on nothing.
package lvr_pkg;

	typedef struct packed {
		logic [23:0] color_red;
		logic [23:0] color_green;
		logic [23:0] color_blue;
		logic [23:0] atten_constant;
		logic [23:0] atten_linear;
		logic [23:0] atten_quadratic;
	} light_t;

	typedef struct packed {
		logic [23:0] radius;
		logic [1:0]  case_code;
	} result_t;

	typedef enum logic [1:0] {
		CASE_ROOT     = 2'd0,
		CASE_FALLBACK = 2'd1,
		CASE_NO_ROOT  = 2'd2,
		CASE_SAT      = 2'd3
	} case_code_t;

	localparam logic [23:0] FALLBACK_RADIUS = 24'd256000;
	localparam logic [23:0] RADIUS_MAX      = 24'hFFFFFF;

	// Stage map of the pipeline
	localparam int DIV5_STEPS = 8;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 24;
	localparam int ST_T    = 0;
	localparam int ST_MUL  = 1;
	localparam int ST_DISC = 2;
	localparam int ST_DIV5 = 3;
	localparam int ST_SQRT = ST_DIV5 + DIV5_STEPS;
	localparam int ST_SUB  = ST_SQRT + SQRT_STEPS;
	localparam int ST_DIV  = ST_SUB + 1;
	localparam int N_STG   = ST_DIV + DIV_STEPS;

	typedef struct packed {
		logic               qz;
		logic               dpos;
		logic               neg;
		logic               ovf;
		logic [23:0]        kl;
		logic [23:0]        kq;
		logic signed [33:0] t;
		logic [50:0]        kl5;
		logic signed [58:0] p;
		logic [63:0]        w;
		logic [2:0]         r5;
		logic [33:0]        srem;
		logic [30:0]        sroot;
		logic [23:0]        drem;
		logic [23:0]        dq;
	} stage_t;

	// One base-256 digit of a division by 5: returns {quotient, remainder}
	function automatic logic [10:0] div5_digit(input logic [10:0] v);
		logic [23:0] prod;
		logic [7:0]  q;
		logic [10:0] q5;
		prod = {13'd0, v} * 24'd1639;
		q    = prod[20:13];
		q5   = {3'd0, q} * 11'd5;
		return {q, 3'(v - q5)};
	endfunction

endpackage

// ----- rtl/light_volume_radius.sv -----
// Light volume radius: cutoff distance of a point light, fully pipelined.
// Depends on lvr_pkg.
//
// Usage:
//  - light channel (light_valid/light_ready/light) carries one light per item:
//    three Q8.16 color channels and three Q8.16 attenuation terms.
//  - result channel (result_valid/result_ready/result) returns one item per
//    light, in order: radius in Q16.8 and a case code.
//  - Throughput is one light per cycle when the result side does not stall.
//  - The pipe is 3 arithmetic stages (max and offset, the two products,
//    discriminant), 8 digit stages of the divide by 5, 31 stages of the
//    square root, one subtract stage, 24 stages of the divider by the
//    quadratic term, and the output register.
//  - Each stage holds its item while the next one is full and stalled, and
//    takes a new item whenever it is empty, so bubbles close up and light
//    items keep being accepted while a finished result waits.
//  - Reset clears every stage valid bit and the output valid; no result is
//    pending after reset.
module light_volume_radius (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              light_valid,
	output logic              light_ready,
	input  lvr_pkg::light_t   light,
	output logic              result_valid,
	input  logic              result_ready,
	output lvr_pkg::result_t  result
);

	lvr_pkg::stage_t pipe_s1 [lvr_pkg::N_STG];
	lvr_pkg::stage_t nxt     [lvr_pkg::N_STG];
	logic [lvr_pkg::N_STG-1:0] vld_s1;
	logic [lvr_pkg::N_STG:0]   en;
	logic                      out_v_q;
	lvr_pkg::result_t          res_q;
	lvr_pkg::result_t          res_d;
	logic [23:0]               cmax;

	assign en[lvr_pkg::N_STG] = !out_v_q || result_ready;
	genvar k;
	generate
		for (k = 0; k < lvr_pkg::N_STG; k++) begin : g_en
			assign en[k] = !vld_s1[k] || en[k+1];
		end
	endgenerate
	assign light_ready = en[0];

	// stage 0: brightest channel and 256*M - 5*K
	always_comb begin
		cmax = light.color_red;
		if (light.color_green > cmax) cmax = light.color_green;
		if (light.color_blue > cmax) cmax = light.color_blue;
		nxt[lvr_pkg::ST_T]    = '0;
		nxt[lvr_pkg::ST_T].qz = (light.atten_quadratic == 24'd0);
		nxt[lvr_pkg::ST_T].kl = light.atten_linear;
		nxt[lvr_pkg::ST_T].kq = light.atten_quadratic;
		nxt[lvr_pkg::ST_T].t  = $signed({2'b00, cmax, 8'd0})
			- $signed({7'd0, light.atten_constant} * 34'd5);
	end

	// stage 1: 5*L*L and Q*T
	always_comb begin
		nxt[lvr_pkg::ST_MUL]     = pipe_s1[lvr_pkg::ST_MUL-1];
		nxt[lvr_pkg::ST_MUL].kl5 = 51'({24'd0, pipe_s1[lvr_pkg::ST_MUL-1].kl}
			* {24'd0, pipe_s1[lvr_pkg::ST_MUL-1].kl}) * 51'd5;
		nxt[lvr_pkg::ST_MUL].p   = $signed({35'd0, pipe_s1[lvr_pkg::ST_MUL-1].kq})
			* $signed({{25{pipe_s1[lvr_pkg::ST_MUL-1].t[33]}},
				pipe_s1[lvr_pkg::ST_MUL-1].t});
	end

	// stage 2: discriminant, its sign, and 16*D
	logic signed [60:0] disc;
	always_comb begin
		disc = $signed({10'd0, pipe_s1[lvr_pkg::ST_DISC-1].kl5})
			+ ($signed({{2{pipe_s1[lvr_pkg::ST_DISC-1].p[58]}},
				pipe_s1[lvr_pkg::ST_DISC-1].p}) <<< 2);
		nxt[lvr_pkg::ST_DISC]      = pipe_s1[lvr_pkg::ST_DISC-1];
		nxt[lvr_pkg::ST_DISC].dpos = !disc[60] && (disc != '0);
		nxt[lvr_pkg::ST_DISC].w    = {disc[59:0], 4'd0};
		nxt[lvr_pkg::ST_DISC].r5   = 3'd0;
	end

	// divide by 5, one byte a stage, quotient written back in place
	generate
		for (k = 0; k < lvr_pkg::DIV5_STEPS; k++) begin : g_div5
			logic [10:0] dr;
			always_comb begin
				nxt[lvr_pkg::ST_DIV5+k] = pipe_s1[lvr_pkg::ST_DIV5+k-1];
				dr = lvr_pkg::div5_digit({pipe_s1[lvr_pkg::ST_DIV5+k-1].r5,
					pipe_s1[lvr_pkg::ST_DIV5+k-1].w[63-8*k -: 8]});
				nxt[lvr_pkg::ST_DIV5+k].w[63-8*k -: 8] = dr[10:3];
				nxt[lvr_pkg::ST_DIV5+k].r5 = dr[2:0];
			end
		end
	endgenerate

	// square root, one result bit a stage
	generate
		for (k = 0; k < lvr_pkg::SQRT_STEPS; k++) begin : g_sqrt
			logic [33:0] trial;
			logic [33:0] cand;
			logic [33:0] rem_in;
			logic [30:0] root_in;
			always_comb begin
				nxt[lvr_pkg::ST_SQRT+k] = pipe_s1[lvr_pkg::ST_SQRT+k-1];
				rem_in  = (k == 0) ? 34'd0 : pipe_s1[lvr_pkg::ST_SQRT+k-1].srem;
				root_in = (k == 0) ? 31'd0 : pipe_s1[lvr_pkg::ST_SQRT+k-1].sroot;
				trial = {rem_in[31:0], pipe_s1[lvr_pkg::ST_SQRT+k-1].w[61-2*k -: 2]};
				cand  = {1'b0, root_in, 2'b01};
				if (trial >= cand) begin
					nxt[lvr_pkg::ST_SQRT+k].srem  = trial - cand;
					nxt[lvr_pkg::ST_SQRT+k].sroot = {root_in[29:0], 1'b1};
				end else begin
					nxt[lvr_pkg::ST_SQRT+k].srem  = trial;
					nxt[lvr_pkg::ST_SQRT+k].sroot = {root_in[29:0], 1'b0};
				end
			end
		end
	endgenerate

	// subtract 4*L, form 32*num, check the quotient range
	logic [30:0] kl4;
	logic [30:0] num;
	logic [35:0] dvd;
	always_comb begin
		nxt[lvr_pkg::ST_SUB] = pipe_s1[lvr_pkg::ST_SUB-1];
		kl4 = {5'd0, pipe_s1[lvr_pkg::ST_SUB-1].kl, 2'b00};
		num = pipe_s1[lvr_pkg::ST_SUB-1].sroot - kl4;
		dvd = {num, 5'd0};
		nxt[lvr_pkg::ST_SUB].neg  = (pipe_s1[lvr_pkg::ST_SUB-1].sroot <= kl4);
		nxt[lvr_pkg::ST_SUB].ovf  = ({12'd0, dvd[35:24]} >= pipe_s1[lvr_pkg::ST_SUB-1].kq);
		nxt[lvr_pkg::ST_SUB].drem = {12'd0, dvd[35:24]};
		nxt[lvr_pkg::ST_SUB].dq   = dvd[23:0];
	end

	// restoring divide by Q, one quotient bit a stage
	generate
		for (k = 0; k < lvr_pkg::DIV_STEPS; k++) begin : g_div
			logic [24:0] r2;
			logic        ge;
			always_comb begin
				nxt[lvr_pkg::ST_DIV+k] = pipe_s1[lvr_pkg::ST_DIV+k-1];
				r2 = {pipe_s1[lvr_pkg::ST_DIV+k-1].drem, pipe_s1[lvr_pkg::ST_DIV+k-1].dq[23]};
				ge = (r2 >= {1'b0, pipe_s1[lvr_pkg::ST_DIV+k-1].kq});
				nxt[lvr_pkg::ST_DIV+k].drem = ge ? 24'(r2 - {1'b0, pipe_s1[lvr_pkg::ST_DIV+k-1].kq})
					: r2[23:0];
				nxt[lvr_pkg::ST_DIV+k].dq = {pipe_s1[lvr_pkg::ST_DIV+k-1].dq[22:0], ge};
			end
		end
	endgenerate

	generate
		for (k = 0; k < lvr_pkg::N_STG; k++) begin : g_reg
			logic take;
			if (k == 0) begin : g_first
				assign take = light_valid;
			end else begin : g_rest
				assign take = vld_s1[k-1];
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1[k] <= 1'b0;
				end else if (en[k]) begin
					vld_s1[k] <= take;
				end
			end
			always_ff @(posedge clk) begin
				if (en[k] && take) begin
					pipe_s1[k] <= nxt[k];
				end
			end
		end
	endgenerate

	// pick the case and the radius
	always_comb begin
		lvr_pkg::stage_t f;
		f = pipe_s1[lvr_pkg::N_STG-1];
		if (f.qz) begin
			res_d.radius    = lvr_pkg::FALLBACK_RADIUS;
			res_d.case_code = lvr_pkg::CASE_FALLBACK;
		end else if (!f.dpos) begin
			res_d.radius    = 24'd0;
			res_d.case_code = lvr_pkg::CASE_NO_ROOT;
		end else if (f.neg) begin
			res_d.radius    = 24'd0;
			res_d.case_code = lvr_pkg::CASE_ROOT;
		end else if (f.ovf) begin
			res_d.radius    = lvr_pkg::RADIUS_MAX;
			res_d.case_code = lvr_pkg::CASE_SAT;
		end else begin
			res_d.radius    = f.dq;
			res_d.case_code = lvr_pkg::CASE_ROOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en[lvr_pkg::N_STG]) begin
			out_v_q <= vld_s1[lvr_pkg::N_STG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[lvr_pkg::N_STG] && vld_s1[lvr_pkg::N_STG-1]) begin
			res_q <= res_d;
		end
	end

	assign result_valid = out_v_q;
	assign result       = res_q;

endmodule

// ----- rtl/lvr_checker.sv -----
// Port checker for light_volume_radius and its bind.
// Depends on lvr_pkg.
module lvr_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              light_ready,
	input logic              result_valid,
	input logic              result_ready,
	input lvr_pkg::result_t  result
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.case_code == lvr_pkg::CASE_FALLBACK
		|-> result.radius == lvr_pkg::FALLBACK_RADIUS)
		else $error("fallback item with wrong radius");

	a_noroot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.case_code == lvr_pkg::CASE_NO_ROOT |-> result.radius == 24'd0)
		else $error("no-root item with nonzero radius");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.case_code == lvr_pkg::CASE_SAT
		|-> result.radius == lvr_pkg::RADIUS_MAX)
		else $error("saturated item below maximum");

	// a free output never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> light_ready)
		else $error("input blocked with empty output");

endmodule

bind light_volume_radius lvr_port_checker u_lvr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.light_ready  (light_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
